[rtl/mpsk_correlation_demodulator_macros.svh]
// ----------------------------------------------------------------------------
// mpsk correlation demodulator assertion macros
// concurrent assertion wrappers for the demodulator rtl
// ----------------------------------------------------------------------------
`ifndef MPSK_CORRELATION_DEMODULATOR_MACROS_SVH
`define MPSK_CORRELATION_DEMODULATOR_MACROS_SVH

// checked only outside reset
`define MCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define MCD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mcd_pkg.sv]
// ----------------------------------------------------------------------------
// mcd_pkg
// types, constants and reference tables of the m-psk correlation demodulator
// ----------------------------------------------------------------------------
package mcd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PROD_W     = 32;
  localparam int ACC_W      = 40;
  localparam int SUM_W      = ACC_W + 1;
  localparam int BPS_W      = 3;
  localparam int ROM_DEPTH  = 16;
  localparam int ROM_BITS   = 4;
  localparam int MAX_PHASES = 16;
  localparam int MAX_LOG2   = $clog2(MAX_PHASES + 1) - 1;
  localparam int MAX_BITS   = (MAX_LOG2 < ROM_BITS) ? MAX_LOG2 : ROM_BITS;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  localparam logic [BPS_W-1:0] BPS_RESET = BPS_W'(1);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [ROM_BITS-1:0]        phase_t;
  typedef logic [BPS_W-1:0]           bps_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_Q,
    ST_ACC,
    ST_EMIT
  } mcd_state_t;

  typedef struct packed {
    logic load_prod;
    logic load_psum;
  } mcd_mac_ctl_t;

  localparam sample_t ROM_COS [ROM_DEPTH] = '{
    16'sd32767,  16'sd30274,  16'sd23170,  16'sd12540,
    16'sd0,     -16'sd12540, -16'sd23170, -16'sd30274,
    -16'sd32768, -16'sd30274, -16'sd23170, -16'sd12540,
    16'sd0,      16'sd12540,  16'sd23170,  16'sd30274
  };

  localparam sample_t ROM_SIN [ROM_DEPTH] = '{
    16'sd0,      16'sd12540,  16'sd23170,  16'sd30274,
    16'sd32767,  16'sd30274,  16'sd23170,  16'sd12540,
    16'sd0,     -16'sd12540, -16'sd23170, -16'sd30274,
    -16'sd32768, -16'sd30274, -16'sd23170, -16'sd12540
  };

  // clamp the register to the supported range of phase bits
  function automatic bps_t eff_bits(input bps_t b);
    bps_t r;
    r = b;
    if (r < BPS_W'(1)) begin
      r = BPS_W'(1);
    end
    if (r > BPS_W'(MAX_BITS)) begin
      r = BPS_W'(MAX_BITS);
    end
    return r;
  endfunction

  // highest phase index in use, m - 1
  function automatic phase_t last_phase(input bps_t eb);
    phase_t m;
    m = '1;
    m = ~(m << eb);
    return m;
  endfunction

  // reference table index for a phase, k * (rom_depth / m)
  function automatic phase_t rom_index(input phase_t k, input bps_t eb);
    bps_t sh;
    sh = BPS_W'(ROM_BITS) - eb;
    return phase_t'(k << sh);
  endfunction

endpackage

[rtl/mcd_if.sv]
// ----------------------------------------------------------------------------
// mcd channel interfaces
// valid/ready channels for samples, decisions and the configuration register
// ----------------------------------------------------------------------------
interface mcd_in_if;
  logic                valid;
  logic                ready;
  mcd_pkg::sample_t    sample_i;
  mcd_pkg::sample_t    sample_q;
  logic                symbol_clock;

  modport source (output valid, output sample_i, output sample_q, output symbol_clock,
                  input ready);
  modport sink   (input valid, input sample_i, input sample_q, input symbol_clock,
                  output ready);
endinterface

interface mcd_out_if;
  logic            valid;
  logic            ready;
  mcd_pkg::phase_t symbol_decision;

  modport source (output valid, output symbol_decision, input ready);
  modport sink   (input valid, input symbol_decision, output ready);
endinterface

interface mcd_cfg_if;
  logic          valid;
  logic          ready;
  mcd_pkg::bps_t bits_per_symbol;

  modport source (output valid, output bits_per_symbol, input ready);
  modport sink   (input valid, input bits_per_symbol, output ready);
endinterface

[rtl/mcd_mac.sv]
// ----------------------------------------------------------------------------
// mcd_mac
// shared multiplier with product and partial-sum registers and a saturating
// accumulate of the two products onto one accumulator
// ----------------------------------------------------------------------------
module mcd_mac (
  input  logic                  clk,
  input  mcd_pkg::mcd_mac_ctl_t ctl,
  input  mcd_pkg::sample_t      op_a,
  input  mcd_pkg::sample_t      op_b,
  input  mcd_pkg::acc_t         acc_in,
  output mcd_pkg::acc_t         acc_out
);

  logic signed [mcd_pkg::PROD_W-1:0] prod_r;
  logic signed [mcd_pkg::PROD_W-1:0] prod_nxt;
  logic signed [mcd_pkg::PROD_W-1:0] psum_r;
  logic signed [mcd_pkg::SUM_W-1:0]  sum;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctl.load_psum) begin
      psum_r <= prod_r;
    end
  end

  assign sum = mcd_pkg::SUM_W'(acc_in) + mcd_pkg::SUM_W'(psum_r) + mcd_pkg::SUM_W'(prod_r);

  always_comb begin
    if (sum > mcd_pkg::SUM_W'(mcd_pkg::ACC_MAX)) begin
      acc_out = mcd_pkg::ACC_MAX;
    end else if (sum < mcd_pkg::SUM_W'(mcd_pkg::ACC_MIN)) begin
      acc_out = mcd_pkg::ACC_MIN;
    end else begin
      acc_out = sum[mcd_pkg::ACC_W-1:0];
    end
  end

endmodule

[rtl/mpsk_correlation_demodulator.sv]
// an accepted request with symbol_clock set shows its decision after all M phases, M = 2^bits_per_symbol
// a new request is taken only in idle, after the previous request has finished all its phases
// each phase steps through three states on the single shared 16x16 multiplier (i product,
//   q product, saturating accumulate); with symbol_clock set each accumulate also runs the max search
// reset: bits_per_symbol returns to 1, all accumulators clear, no result pending
// ----------------------------------------------------------------------------
// mpsk_correlation_demodulator
// coherent m-psk integrate-and-dump detector over a shared multiply-accumulate
// ----------------------------------------------------------------------------
`include "mpsk_correlation_demodulator_macros.svh"

module mpsk_correlation_demodulator (
  input  logic       clk,
  input  logic       rst_n,
  mcd_in_if.sink     in_ch,
  mcd_out_if.source  out_ch,
  mcd_cfg_if.sink    cfg_ch
);

  mcd_pkg::mcd_state_t   state_r;
  mcd_pkg::mcd_state_t   state_nxt;
  mcd_pkg::phase_t       k_r;
  mcd_pkg::phase_t       k_nxt;
  mcd_pkg::sample_t      si_r;
  mcd_pkg::sample_t      sq_r;
  logic                  flag_r;
  mcd_pkg::bps_t         bps_r;
  mcd_pkg::acc_t         acc_r [mcd_pkg::ROM_DEPTH];
  mcd_pkg::acc_t         best_r;
  mcd_pkg::phase_t       best_idx_r;
  logic                  out_valid_r;
  mcd_pkg::phase_t       decision_r;

  mcd_pkg::bps_t         eb;
  mcd_pkg::phase_t       last_k;
  mcd_pkg::phase_t       rom_j;
  mcd_pkg::mcd_mac_ctl_t mac_ctl;
  mcd_pkg::sample_t      op_a;
  mcd_pkg::sample_t      op_b;
  mcd_pkg::acc_t         acc_new;
  logic                  in_acc;
  logic                  cfg_wr;
  logic                  acc_wr;
  logic                  best_wr;
  logic                  out_load;

  assign eb     = mcd_pkg::eff_bits(bps_r);
  assign last_k = mcd_pkg::last_phase(eb);
  assign rom_j  = mcd_pkg::rom_index(k_r, eb);

  assign in_ch.ready   = (state_r == mcd_pkg::ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready  = 1'b1;
  assign cfg_wr        = cfg_ch.valid && cfg_ch.ready;

  assign out_ch.valid           = out_valid_r;
  assign out_ch.symbol_decision = decision_r;

  assign op_a = (state_r == mcd_pkg::ST_MUL_Q) ? sq_r : si_r;
  assign op_b = (state_r == mcd_pkg::ST_MUL_Q) ? mcd_pkg::ROM_SIN[rom_j]
                                               : mcd_pkg::ROM_COS[rom_j];

  mcd_mac u_mac (
    .clk     (clk),
    .ctl     (mac_ctl),
    .op_a    (op_a),
    .op_b    (op_b),
    .acc_in  (acc_r[k_r]),
    .acc_out (acc_new)
  );

  always_comb begin
    state_nxt         = state_r;
    k_nxt             = k_r;
    mac_ctl.load_prod = 1'b0;
    mac_ctl.load_psum = 1'b0;
    acc_wr            = 1'b0;
    best_wr           = 1'b0;
    out_load          = 1'b0;
    case (state_r)
      mcd_pkg::ST_IDLE: begin
        if (in_acc) begin
          k_nxt     = '0;
          state_nxt = mcd_pkg::ST_MUL_I;
        end
      end
      mcd_pkg::ST_MUL_I: begin
        mac_ctl.load_prod = 1'b1;
        state_nxt         = mcd_pkg::ST_MUL_Q;
      end
      mcd_pkg::ST_MUL_Q: begin
        mac_ctl.load_prod = 1'b1;
        mac_ctl.load_psum = 1'b1;
        state_nxt         = mcd_pkg::ST_ACC;
      end
      mcd_pkg::ST_ACC: begin
        acc_wr  = 1'b1;
        best_wr = flag_r && ((k_r == '0) || (acc_new > best_r));
        if (k_r == last_k) begin
          state_nxt = flag_r ? mcd_pkg::ST_EMIT : mcd_pkg::ST_IDLE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = mcd_pkg::ST_MUL_I;
        end
      end
      mcd_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = mcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcd_pkg::ST_IDLE;
      k_r         <= '0;
      bps_r       <= mcd_pkg::BPS_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < mcd_pkg::ROM_DEPTH; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      if (cfg_wr) begin
        bps_r <= cfg_ch.bits_per_symbol;
        for (int i = 0; i < mcd_pkg::ROM_DEPTH; i++) begin
          acc_r[i] <= '0;
        end
      end else if (acc_wr) begin
        acc_r[k_r] <= flag_r ? '0 : acc_new;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      si_r   <= in_ch.sample_i;
      sq_r   <= in_ch.sample_q;
      flag_r <= in_ch.symbol_clock;
    end
    if (best_wr) begin
      best_r     <= acc_new;
      best_idx_r <= k_r;
    end
    if (out_load) begin
      decision_r <= best_idx_r;
    end
  end

  `MCD_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == mcd_pkg::ST_IDLE) && !out_valid_r, "reset did not return to idle")
  `MCD_ASSERT(a_start_phase0, in_acc |=> (state_r == mcd_pkg::ST_MUL_I) && (k_r == '0), "request did not start at phase zero")
  `MCD_ASSERT(a_phase_range, (state_r != mcd_pkg::ST_IDLE) |-> (k_r <= last_k), "phase counter beyond constellation size")
  `MCD_ASSERT(a_rise_from_emit, $rose(out_valid_r) |-> $past(state_r == mcd_pkg::ST_EMIT), "decision raised outside emit")
  `MCD_ASSERT(a_decision_range, out_valid_r |-> (decision_r <= last_k), "decision index beyond constellation size")

endmodule
